@@ rtl/core/sigil_run_length_frame_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the run-length frame decoder
// Shared immediate-style wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SIGIL_RUN_LENGTH_FRAME_DECODER_MACROS_SVH
`define SIGIL_RUN_LENGTH_FRAME_DECODER_MACROS_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define SRLFD_ASSERT_SAME(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// The condition must never hold.
`define SRLFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

@@ rtl/core/srlfd_pkg.sv @@
// ----------------------------------------------------------------------------
// srlfd_pkg
// Types and constants shared by the run-length frame decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srlfd_pkg;

	localparam int unsigned MAX_CHAIN   = 15;
	localparam int unsigned CHAIN_W     = 4;
	localparam int unsigned NUM_SLOTS   = 6;
	localparam int unsigned SLOT_W      = 3;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_Z    = 2'd1;
	localparam logic [1:0] KIND_F    = 2'd2;
	localparam logic [1:0] KIND_R    = 2'd3;

	localparam logic [1:0] ITEM_LITERAL = 2'd0;
	localparam logic [1:0] ITEM_RUN     = 2'd1;
	localparam logic [1:0] ITEM_DONE    = 2'd2;
	localparam logic [1:0] ITEM_ERROR   = 2'd3;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_CORRUPT = 2'd1;
	localparam logic [1:0] ERR_SMALL   = 2'd2;

	// Fixed result positions within one input byte's work, in output order.
	localparam int unsigned SLOT_REPEAT = 0;
	localparam int unsigned SLOT_HELD   = 1;
	localparam int unsigned SLOT_FIRST  = 2;
	localparam int unsigned SLOT_SECOND = 3;
	localparam int unsigned SLOT_TAIL   = 4;
	localparam int unsigned SLOT_DONE   = 5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [31:0] len;
	} slot_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]  valid;
		logic                  start;
		slot_t [NUM_SLOTS-1:0] slots;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/core/srlfd_front.sv @@
// ----------------------------------------------------------------------------
// srlfd_front
// Classifies each byte, chains sigils into counts and lists its results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srlfd_front
	import srlfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       frame_start_byte,
	output entry_t          entry,
	output logic            entry_valid
);

	logic [1:0]         ck_q, hk_q;
	logic [CHAIN_W-1:0] cl_q;
	logic [31:0]        acc_q, pw_q, hl_q, rl_q;
	logic [4:0]         ll_q;
	logic               aw_q;

	logic [1:0]         ck_n, hk_n, ck_c, kind;
	logic [CHAIN_W-1:0] cl_n, cl_c;
	logic [31:0]        acc_n, pw_n, hl_n, rl_n, acc_c, pw_c, acc_sum, weighted;
	logic [4:0]         ll_n, dc;
	logic [1:0]         digit;
	logic               aw_n, stop, start;
	entry_t             ent;

	function automatic logic [7:0] run_byte(input logic [1:0] k);
		return (k == KIND_Z) ? 8'h00 : 8'hFF;
	endfunction

	always_comb begin
		start = frame_start_byte;
		kind  = KIND_NONE;
		digit = 2'd0;
		dc    = in_byte[4:0];
		priority if (in_byte < 8'h20) begin
			kind = KIND_NONE;
		end else if (in_byte < 8'h40) begin
			kind = KIND_Z; digit = 2'd0;
		end else if (in_byte < 8'h50) begin
			kind = KIND_R; digit = 2'd1; dc = {1'b0, in_byte[3:0]};
		end else if (in_byte < 8'h60) begin
			kind = KIND_Z; digit = 2'd2; dc = {1'b0, in_byte[3:0]};
		end else if (in_byte < 8'h80) begin
			kind = KIND_Z; digit = 2'd1;
		end else if (in_byte < 8'hA0) begin
			kind = KIND_R; digit = 2'd0;
		end else if (in_byte < 8'hB0) begin
			kind = KIND_R; digit = 2'd2; dc = {1'b0, in_byte[3:0]};
		end else if (in_byte < 8'hC0) begin
			kind = KIND_Z; digit = 2'd3; dc = {1'b0, in_byte[3:0]};
		end else if (in_byte < 8'hE0) begin
			kind = KIND_F; digit = 2'd1;
		end else if (in_byte < 8'hF0) begin
			kind = KIND_F; digit = 2'd2; dc = {1'b0, in_byte[3:0]};
		end else if (in_byte == 8'hFF) begin
			kind = KIND_F; digit = 2'd0; dc = 5'd0;
		end else begin
			kind = KIND_F; digit = 2'd3; dc = {1'b0, in_byte[3:0]};
		end
	end

	always_comb begin
		ent       = '0;
		ent.start = start;
		ck_n = ck_q; cl_n = cl_q; acc_n = acc_q; pw_n = pw_q;
		ll_n = ll_q; hk_n = hk_q; hl_n = hl_q; aw_n = aw_q; rl_n = rl_q;
		ck_c = ck_q; cl_c = cl_q; acc_c = acc_q; pw_c = pw_q;
		acc_sum  = '0;
		weighted = '0;
		stop     = 1'b0;

		// A finished repeat run takes this byte as its value.
		if (aw_q) begin
			ent.valid[SLOT_REPEAT] = 1'b1;
			ent.slots[SLOT_REPEAT] = '{ITEM_RUN, in_byte, rl_q + 32'd1};
			if (hk_q != KIND_NONE) begin
				ent.valid[SLOT_HELD] = 1'b1;
				ent.slots[SLOT_HELD] = '{ITEM_RUN, run_byte(hk_q), hl_q};
			end
			aw_n = 1'b0; hk_n = KIND_NONE; hl_n = '0; rl_n = '0;
		end

		if (ll_q != 5'd0) begin
			ll_n = ll_q - 5'd1;
			ent.valid[SLOT_FIRST] = 1'b1;
			ent.slots[SLOT_FIRST] = '{ITEM_LITERAL, in_byte, 32'd1};
			if (start && (ll_n != 5'd0)) begin
				ent.valid[SLOT_SECOND] = 1'b1;
				ent.slots[SLOT_SECOND] = '{ITEM_ERROR, 8'h00, 32'd0};
			end
		end else begin
			// A byte that is not a sigil of the open chain's kind closes the chain.
			if ((ck_q != KIND_NONE) && (ck_q != kind)) begin
				ck_c = KIND_NONE; cl_c = '0; acc_c = '0; pw_c = 32'd1;
				if (ck_q == KIND_R) begin
					if (start) begin
						ent.valid[SLOT_FIRST] = 1'b1;
						ent.slots[SLOT_FIRST] = '{ITEM_ERROR, 8'h00, 32'd0};
						stop = 1'b1;
					end else begin
						aw_n = 1'b1; rl_n = acc_q;
					end
				end else if (aw_n) begin
					hk_n = ck_q; hl_n = acc_q;
				end else begin
					ent.valid[SLOT_FIRST] = 1'b1;
					ent.slots[SLOT_FIRST] = '{ITEM_RUN, run_byte(ck_q), acc_q};
				end
			end
			ck_n = ck_c; cl_n = cl_c; acc_n = acc_c; pw_n = pw_c;

			if (!stop && (kind != KIND_NONE)) begin
				if (cl_c >= CHAIN_W'(MAX_CHAIN)) begin
					ent.valid[SLOT_SECOND] = 1'b1;
					ent.slots[SLOT_SECOND] = '{ITEM_ERROR, 8'h00, 32'd0};
					stop = 1'b1;
				end else begin
					unique case (digit)
						2'd0:    weighted = pw_c;
						2'd1:    weighted = pw_c << 1;
						2'd2:    weighted = pw_c + (pw_c << 1);
						default: weighted = pw_c << 2;
					endcase
					acc_sum = acc_c + weighted;
					acc_n   = acc_sum;
					pw_n    = (kind == KIND_R) ? (pw_c + (pw_c << 1)) : (pw_c << 2);
					cl_n    = cl_c + CHAIN_W'(1);
					ck_n    = kind;
					if ((dc != 5'd0) || start) begin
						ck_n = KIND_NONE; cl_n = '0; acc_n = '0; pw_n = 32'd1;
						if (kind == KIND_R) begin
							if (start) begin
								ent.valid[SLOT_SECOND] = 1'b1;
								ent.slots[SLOT_SECOND] = '{ITEM_ERROR, 8'h00, 32'd0};
								stop = 1'b1;
							end else begin
								aw_n = 1'b1; rl_n = acc_sum;
							end
						end else if (aw_n) begin
							hk_n = kind; hl_n = acc_sum;
						end else begin
							ent.valid[SLOT_SECOND] = 1'b1;
							ent.slots[SLOT_SECOND] = '{ITEM_RUN, run_byte(kind), acc_sum};
						end
					end
				end
			end

			if (!stop) begin
				if (start && (dc != 5'd0)) begin
					ent.valid[SLOT_TAIL] = 1'b1;
					ent.slots[SLOT_TAIL] = '{ITEM_ERROR, 8'h00, 32'd0};
				end else begin
					ll_n = dc;
				end
			end
		end

		if (start) begin
			ent.valid[SLOT_DONE] = 1'b1;
			ent.slots[SLOT_DONE] = '{ITEM_DONE, 8'h00, 32'd0};
			ck_n = KIND_NONE; cl_n = '0; acc_n = '0; pw_n = 32'd1;
			ll_n = '0; hk_n = KIND_NONE; hl_n = '0; aw_n = 1'b0; rl_n = '0;
		end
	end

	assign entry       = ent;
	assign entry_valid = |ent.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_q <= KIND_NONE; cl_q <= '0; acc_q <= '0; pw_q <= 32'd1;
			ll_q <= '0; hk_q <= KIND_NONE; hl_q <= '0; aw_q <= 1'b0; rl_q <= '0;
		end else if (accept) begin
			ck_q <= ck_n; cl_q <= cl_n; acc_q <= acc_n; pw_q <= pw_n;
			ll_q <= ll_n; hk_q <= hk_n; hl_q <= hl_n; aw_q <= aw_n; rl_q <= rl_n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/srlfd_queue.sv @@
// ----------------------------------------------------------------------------
// srlfd_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srlfd_queue
	import srlfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  entry_t    wr_data,
	output logic      full,
	input  wire logic rd_en,
	output entry_t    rd_data,
	output logic      rd_valid
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/srlfd_back.sv @@
// ----------------------------------------------------------------------------
// srlfd_back
// Issues listed results one per cycle while pop keeps up, counts output and checks capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srlfd_back
	import srlfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  entry_t           head,
	input  wire logic        head_valid,
	output logic             head_pop,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_data,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       item_kind,
	output logic [7:0]       byte_value,
	output logic [31:0]      run_length,
	output logic [1:0]       error_code,
	output logic             last_of_input
);

	logic [31:0]          max_len_q, dec_q, dec_n;
	logic                 failed_q, failed_n;
	logic [NUM_SLOTS-1:0] used_q, used_n, cur, after;
	logic                 out_valid_q, adv, produce, finish;
	logic [1:0]           kind_n, err_n;
	logic [7:0]           byte_n;
	logic [31:0]          len_n;
	logic                 last_n;
	logic [SLOT_W-1:0]    sel;
	slot_t                slot;
	logic [32:0]          sum;

	assign adv = !out_valid_q || pop;
	assign cur = head.valid & ~used_q;

	always_comb begin
		sel = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (cur[i]) begin
				sel = SLOT_W'(i);
			end
		end
	end

	assign after = cur & ~(NUM_SLOTS'(1) << sel);
	assign slot  = head.slots[sel];
	assign sum   = {1'b0, dec_q} + {1'b0, slot.len};

	always_comb begin
		produce  = 1'b0;
		finish   = 1'b0;
		kind_n   = slot.kind;
		byte_n   = slot.value;
		len_n    = slot.len;
		err_n    = ERR_NONE;
		last_n   = 1'b1;
		dec_n    = dec_q;
		failed_n = failed_q;
		used_n   = used_q;
		if (head_valid && adv) begin
			if (failed_q) begin
				finish = 1'b1;
			end else begin
				produce = 1'b1;
				unique case (slot.kind)
					ITEM_LITERAL, ITEM_RUN: begin
						if (sum > {1'b0, max_len_q}) begin
							kind_n   = ITEM_ERROR;
							byte_n   = 8'h00;
							len_n    = dec_q;
							err_n    = ERR_SMALL;
							failed_n = 1'b1;
							finish   = 1'b1;
						end else begin
							dec_n  = sum[31:0];
							last_n = (after == '0);
							finish = (after == '0);
						end
					end
					ITEM_ERROR: begin
						len_n    = dec_q;
						err_n    = ERR_CORRUPT;
						failed_n = 1'b1;
						finish   = 1'b1;
					end
					default: begin
						len_n  = dec_q;
						finish = 1'b1;
					end
				endcase
			end
			if (finish) begin
				used_n = '0;
				if (head.start) begin
					failed_n = 1'b0;
					dec_n    = '0;
				end
			end else begin
				used_n = used_q | (NUM_SLOTS'(1) << sel);
			end
		end
	end

	assign head_pop = finish;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk) begin
		if (produce) begin
			item_kind     <= kind_n;
			byte_value    <= byte_n;
			run_length    <= len_n;
			error_code    <= err_n;
			last_of_input <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= 32'hFFFF_FFFF;
			dec_q       <= '0;
			failed_q    <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_data;
			end
			dec_q    <= dec_n;
			failed_q <= failed_n;
			used_q   <= used_n;
			if (adv) begin
				out_valid_q <= produce;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sigil_run_length_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// sigil_run_length_frame_decoder
// Decodes sigil-coded run-length frames, fed last byte first, into run items.
// ----------------------------------------------------------------------------
// Input side: a byte is transferred when push is high and full is low; the
// frame_start_byte flag marks the frame's first byte, which arrives last.
// Result side: while empty is low the oldest result sits on the result ports,
// and it is transferred when pop is high. Results keep the fed (reverse)
// order; last_of_input marks the final result caused by one input byte.
// The max_output_length register is written whenever max_output_length_we
// is high; write it only while the decoder holds no unfinished work.
// A byte's results pass through the queue to the registered result ports.
// Throughput: one byte per cycle while full is low, and one result per cycle
// on the output while pop keeps up. A byte with more than one result holds
// the issue stage until all are issued; the front keeps taking bytes until
// its four-entry queue fills, then raises full. Bytes that cause no result
// never reach the queue. A stalled receiver holds the output register; the
// queue then fills and full backs up the sender. Reset clears all frame
// state, empties the queue and sets the output capacity to its largest value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sigil_run_length_frame_decoder_macros.svh"

module sigil_run_length_frame_decoder
	import srlfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	input  wire logic        frame_start_byte,
	input  wire logic        max_output_length_we,
	input  wire logic [31:0] max_output_length,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       item_kind,
	output logic [7:0]       byte_value,
	output logic [31:0]      run_length,
	output logic [1:0]       error_code,
	output logic             last_of_input
);

	// Front: sigil classification and chain counting, one byte per cycle while full is low.
	entry_t front_entry;
	logic   front_has_results;
	logic   accept;
	entry_t head;
	logic   head_valid;
	logic   head_pop;

	assign accept = push && !full;

	srlfd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.in_byte          (in_byte),
		.frame_start_byte (frame_start_byte),
		.entry            (front_entry),
		.entry_valid      (front_has_results)
	);

	// Only bytes with at least one listed result are queued.
	srlfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && front_has_results),
		.wr_data  (front_entry),
		.full     (full),
		.rd_en    (head_pop),
		.rd_data  (head),
		.rd_valid (head_valid)
	);

	// Back: output counting, capacity check and failure suppression.
	srlfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.head_pop      (head_pop),
		.cfg_we        (max_output_length_we),
		.cfg_data      (max_output_length),
		.pop           (pop),
		.empty         (empty),
		.item_kind     (item_kind),
		.byte_value    (byte_value),
		.run_length    (run_length),
		.error_code    (error_code),
		.last_of_input (last_of_input)
	);

	`SRLFD_ASSERT_SAME(a_error_closes_byte, clk, arst_n,
		!empty && item_kind == ITEM_ERROR, last_of_input,
		"error result must be the last of its byte")
	`SRLFD_ASSERT_SAME(a_done_closes_byte, clk, arst_n,
		!empty && item_kind == ITEM_DONE, last_of_input && error_code == ERR_NONE,
		"frame done must be last and error free")
	`SRLFD_ASSERT_SAME(a_code_only_on_error, clk, arst_n,
		!empty && item_kind != ITEM_ERROR, error_code == ERR_NONE,
		"error code on a non-error result")
	`SRLFD_ASSERT_NEVER(a_literal_length, clk, arst_n,
		!empty && item_kind == ITEM_LITERAL && run_length != 32'd1,
		"literal result with length other than one")

endmodule

`default_nettype wire
